// ----- sv/two_channel_frame_averager_macros.svh -----
// ----------------------------------------------------------------------------
// Two-channel frame averager assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef TWO_CHANNEL_FRAME_AVERAGER_MACROS_SVH
`define TWO_CHANNEL_FRAME_AVERAGER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCFA_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCFA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/tcfa_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame averager package
// Widths, reset values, register codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package tcfa_pkg;

    localparam int DEF_FRAME_DEPTH  = 1024;
    localparam int DEF_SAMPLE_WIDTH = 24;

    localparam int AVG_W      = 9;
    localparam int LEN_W      = 11;
    localparam int ELEM_W     = 10;
    localparam int FRAMES_W   = 8;
    localparam int SUM_W      = 32;
    localparam int TOT_W      = SUM_W + 1;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam int NUM_LANES  = 2;
    localparam int DIV_STEP_BITS = 4;

    localparam logic [AVG_W-1:0] AVG_RESET = 9'd16;
    localparam logic [AVG_W-1:0] AVG_MAX   = 9'd256;
    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    localparam int LANE_LEFT  = 0;
    localparam int LANE_RIGHT = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AVG_COUNT,
        CFG_FRAME_LENGTH
    } t_cfg_reg;

    typedef struct packed {
        logic clearing;
        logic last_elem;
        logic last_frame;
    } t_seq_stat;

    typedef struct packed {
        logic [ELEM_W-1:0] elem_index;
        logic              last;
    } t_div_tag;

endpackage

`default_nettype wire

// ----- sv/tcfa_if.sv -----
// ----------------------------------------------------------------------------
// Frame averager channel interfaces
// Sample input, averaged output and register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcfa_in_if #(
    parameter int SAMPLE_WIDTH = tcfa_pkg::DEF_SAMPLE_WIDTH
);
    logic                    valid;
    logic                    ready;
    logic [SAMPLE_WIDTH-1:0] left_sample;
    logic [SAMPLE_WIDTH-1:0] right_sample;

    modport source (output valid, left_sample, right_sample, input ready);
    modport sink   (input valid, left_sample, right_sample, output ready);
endinterface

interface tcfa_out_if #(
    parameter int SAMPLE_WIDTH = tcfa_pkg::DEF_SAMPLE_WIDTH
);
    logic                        valid;
    logic                        ready;
    logic [SAMPLE_WIDTH-1:0]     left_average;
    logic [SAMPLE_WIDTH-1:0]     right_average;
    logic [tcfa_pkg::ELEM_W-1:0] element_index;
    logic                        last_of_frame;

    modport source (output valid, left_average, right_average, element_index,
                    last_of_frame, input ready);
    modport sink   (input valid, left_average, right_average, element_index,
                    last_of_frame, output ready);
endinterface

interface tcfa_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tcfa_pkg::CFG_IDX_W-1:0]  index;
    logic [tcfa_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/tcfa_mem.sv -----
// ----------------------------------------------------------------------------
// Frame averager sum memory
// One write port, one registered read port, write data forwarded on collision.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfa_mem #(
    parameter  int DEPTH = tcfa_pkg::DEF_FRAME_DEPTH,
    parameter  int WIDTH = tcfa_pkg::SUM_W,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read-modify-write back to back on one entry: pass the new value through.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- sv/tcfa_seq.sv -----
// ----------------------------------------------------------------------------
// Frame averager sequencer
// Element position, frame count and the post-reset clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_channel_frame_averager_macros.svh"

module tcfa_seq #(
    parameter  int FRAME_DEPTH = tcfa_pkg::DEF_FRAME_DEPTH,
    localparam int POS_W       = $clog2(FRAME_DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [tcfa_pkg::AVG_W-1:0] i_avg_count,
    input  logic [tcfa_pkg::LEN_W-1:0] i_frame_length,
    output tcfa_pkg::t_seq_stat        o_stat,
    output logic [POS_W-1:0]           o_pos,
    output logic [tcfa_pkg::AVG_W-1:0] o_divisor
);
    import tcfa_pkg::*;

    localparam int LW = (LEN_W > POS_W + 1) ? LEN_W : POS_W + 1;

    logic                r_clearing;
    logic [POS_W-1:0]    r_pos;
    logic [FRAMES_W-1:0] r_frames;

    logic [AVG_W-1:0] avg_eff;
    logic [LEN_W-1:0] len_nz;
    logic [LW-1:0]    len_eff;
    logic             last_elem;
    logic             last_frame;

    // Clamp the registers into their working ranges.
    always_comb begin
        if (i_avg_count == '0) begin
            avg_eff = AVG_W'(1);
        end else if (i_avg_count > AVG_MAX) begin
            avg_eff = AVG_MAX;
        end else begin
            avg_eff = i_avg_count;
        end
        len_nz     = (i_frame_length == '0) ? LEN_W'(1) : i_frame_length;
        len_eff    = (LW'(len_nz) > LW'(FRAME_DEPTH)) ? LW'(FRAME_DEPTH) : LW'(len_nz);
        last_elem  = LW'(r_pos) >= (len_eff - LW'(1));
        last_frame = AVG_W'(r_frames) >= (avg_eff - AVG_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_pos      <= '0;
            r_frames   <= '0;
        end else if (r_clearing) begin
            if (r_pos == POS_W'(FRAME_DEPTH - 1)) begin
                r_clearing <= 1'b0;
                r_pos      <= '0;
            end else begin
                r_pos <= r_pos + POS_W'(1);
            end
        end else if (i_accept) begin
            if (last_elem) begin
                r_pos    <= '0;
                r_frames <= last_frame ? '0 : r_frames + FRAMES_W'(1);
            end else begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    assign o_stat.clearing   = r_clearing;
    assign o_stat.last_elem  = last_elem;
    assign o_stat.last_frame = last_frame;
    assign o_pos             = r_pos;
    assign o_divisor         = avg_eff;

    `TCFA_ASSERT_IMP(a_no_accept_in_clear, i_clk, i_rst_n, r_clearing, !i_accept, "item accepted during clearing pass")
    `TCFA_ASSERT_IMP(a_clear_ends_home, i_clk, i_rst_n, $fell(r_clearing), (r_pos == '0) && (r_frames == '0), "counters not home after clearing pass")
    `TCFA_ASSERT_NXT(a_frame_wraps, i_clk, i_rst_n, !r_clearing && i_accept && last_elem, r_pos == '0, "position did not wrap after last element")

endmodule

`default_nettype wire

// ----- sv/tcfa_div.sv -----
// ----------------------------------------------------------------------------
// Frame averager divider
// Pipelined signed divide by the frame count, both channels, with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module tcfa_div #(
    parameter int SAMPLE_WIDTH = tcfa_pkg::DEF_SAMPLE_WIDTH,
    parameter int STEP_BITS    = tcfa_pkg::DIV_STEP_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  tcfa_pkg::t_div_tag            i_tag,
    input  logic [tcfa_pkg::TOT_W-1:0]    i_total   [tcfa_pkg::NUM_LANES],
    input  logic [tcfa_pkg::AVG_W-1:0]    i_divisor,
    output logic                          o_valid,
    output tcfa_pkg::t_div_tag            o_tag,
    output logic [SAMPLE_WIDTH-1:0]       o_average [tcfa_pkg::NUM_LANES]
);
    import tcfa_pkg::*;

    localparam int STAGES = (TOT_W + STEP_BITS - 1) / STEP_BITS;
    localparam int QW     = STAGES * STEP_BITS;
    localparam int REM_W  = AVG_W;
    localparam logic [QW-1:0] SAT_NEG_MAG = QW'(1) << (SAMPLE_WIDTH - 1);
    localparam logic [QW-1:0] SAT_POS     = SAT_NEG_MAG - QW'(1);

    logic             r_valid [STAGES+1];
    t_div_tag         r_tag   [STAGES+1];
    logic             r_neg   [NUM_LANES][STAGES+1];
    logic [REM_W-1:0] r_rem   [NUM_LANES][STAGES+1];
    logic [QW-1:0]    r_quo   [NUM_LANES][STAGES+1];

    // Entry stage: split the total into sign and magnitude.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (i_en) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
        end
    end

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_entry
        logic [TOT_W-1:0] mag;

        assign mag = i_total[l][TOT_W-1] ? (TOT_W'(0) - i_total[l]) : i_total[l];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[l][0] <= i_total[l][TOT_W-1];
                r_rem[l][0] <= '0;
                r_quo[l][0] <= QW'(mag);
            end
        end
    end

    // Restoring stages: STEP_BITS quotient bits per stage.
    for (genvar k = 1; k <= STAGES; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= r_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[k] <= r_tag[k-1];
            end
        end

        for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
            logic [REM_W-1:0] rem_v;
            logic [QW-1:0]    quo_v;
            logic [REM_W:0]   trial;

            always_comb begin
                rem_v = r_rem[l][k-1];
                quo_v = r_quo[l][k-1];
                trial = '0;
                for (int b = 0; b < STEP_BITS; b++) begin
                    trial = {rem_v, quo_v[QW-1]};
                    quo_v = quo_v << 1;
                    if (trial >= {1'b0, i_divisor}) begin
                        rem_v    = REM_W'(trial - {1'b0, i_divisor});
                        quo_v[0] = 1'b1;
                    end else begin
                        rem_v = REM_W'(trial);
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_neg[l][k] <= r_neg[l][k-1];
                    r_rem[l][k] <= rem_v;
                    r_quo[l][k] <= quo_v;
                end
            end
        end
    end

    // Reapply the sign and clip to the sample range.
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_sat
        logic [QW-1:0] q;

        assign q = r_quo[l][STAGES];

        always_comb begin
            if (r_neg[l][STAGES]) begin
                if (q > SAT_NEG_MAG) begin
                    o_average[l] = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
                end else begin
                    o_average[l] = SAMPLE_WIDTH'(QW'(0) - q);
                end
            end else begin
                if (q > SAT_POS) begin
                    o_average[l] = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
                end else begin
                    o_average[l] = SAMPLE_WIDTH'(q);
                end
            end
        end
    end

    assign o_valid = r_valid[STAGES];
    assign o_tag   = r_tag[STAGES];

endmodule

`default_nettype wire

// ----- sv/two_channel_frame_averager.sv -----
// ----------------------------------------------------------------------------
// Two-channel frame averager
// Coherent averaging of left/right sample frames over a programmable count.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle in every frame, except during the
// clearing pass and while the pipeline is held. Each element's running sums
// live in two synchronous RAMs (left and right, FRAME_DEPTH x 32): an item
// reads its entry on transfer and writes it back from the stage 1 register;
// when the same element comes back in the very next cycle (frame_length of 1)
// the written value is forwarded into the read. On the avg_count-th frame the
// sum plus the incoming sample goes to a pipelined divider (an entry stage,
// then four quotient bits per stage, nine stages) and the entry is zeroed;
// the averaged result passes the divider stages into the output register.
// Items in the other frames give no result. After reset the block clears all
// FRAME_DEPTH entries of the RAMs (1024 by default) one entry per cycle, and
// takes no item until that pass is done; register writes are taken at any
// time and are meant to be made only while the block is idle. A waiting
// result sits in an output register, so input keeps flowing until a result
// reaches the divider tail while the output register still holds one that is
// not taken; the whole pipeline then holds in place.
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_channel_frame_averager_macros.svh"

module two_channel_frame_averager #(
    parameter int FRAME_DEPTH  = tcfa_pkg::DEF_FRAME_DEPTH,
    parameter int SAMPLE_WIDTH = tcfa_pkg::DEF_SAMPLE_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tcfa_cfg_if.sink    i_cfg,
    tcfa_in_if.sink     i_in,
    tcfa_out_if.source  o_out
);
    import tcfa_pkg::*;

    localparam int POS_W = $clog2(FRAME_DEPTH);

    // Configuration registers
    logic [AVG_W-1:0] r_avg_count;
    logic [LEN_W-1:0] r_frame_length;

    // Sequencer view
    t_seq_stat        seq_stat;
    logic [POS_W-1:0] seq_pos;
    logic [AVG_W-1:0] divisor;

    // Pipeline control
    logic in_accept;
    logic advance;

    // Read-modify-write stage
    logic                    r_s1_valid;
    logic [SAMPLE_WIDTH-1:0] r_s1_left;
    logic [SAMPLE_WIDTH-1:0] r_s1_right;
    logic [POS_W-1:0]        r_s1_addr;
    logic                    r_s1_last_frame;
    logic                    r_s1_last_elem;

    logic [SUM_W-1:0] rd_sum  [NUM_LANES];
    logic [TOT_W-1:0] total   [NUM_LANES];
    logic [SUM_W-1:0] wr_sum  [NUM_LANES];
    logic             wr_en;
    logic [POS_W-1:0] wr_addr;

    // Divider output
    logic                    div_valid;
    t_div_tag                div_tag;
    t_div_tag                s1_tag;
    logic [SAMPLE_WIDTH-1:0] div_avg [NUM_LANES];

    // Output register
    logic                    r_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_out_left;
    logic [SAMPLE_WIDTH-1:0] r_out_right;
    t_div_tag                r_out_tag;

    // ------------------------------------------------------------------
    // Register writes: always ready, drop writes to unknown indexes.
    // ------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_count    <= AVG_RESET;
            r_frame_length <= LEN_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                CFG_AVG_COUNT: begin
                    r_avg_count <= i_cfg.data[AVG_W-1:0];
                end
                CFG_FRAME_LENGTH: begin
                    r_frame_length <= i_cfg.data[LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Whole pipeline advances together; hold only when the divider tail
    // has a result and the output register cannot take it.
    // ------------------------------------------------------------------
    assign advance    = !div_valid || !r_out_valid || o_out.ready;
    assign i_in.ready = !seq_stat.clearing && advance;
    assign in_accept  = i_in.valid && i_in.ready;

    tcfa_seq #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_avg_count    (r_avg_count),
        .i_frame_length (r_frame_length),
        .o_stat         (seq_stat),
        .o_pos          (seq_pos),
        .o_divisor      (divisor)
    );

    // ------------------------------------------------------------------
    // Sum memories: read at transfer, write back from stage 1, or zero
    // one entry per cycle during the clearing pass.
    // ------------------------------------------------------------------
    assign wr_en   = seq_stat.clearing || (r_s1_valid && advance);
    assign wr_addr = seq_stat.clearing ? seq_pos : r_s1_addr;

    tcfa_mem #(
        .DEPTH (FRAME_DEPTH),
        .WIDTH (SUM_W)
    ) u_mem_left (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (seq_stat.clearing ? '0 : wr_sum[LANE_LEFT]),
        .i_rd_en   (in_accept),
        .i_rd_addr (seq_pos),
        .o_rd_data (rd_sum[LANE_LEFT])
    );

    tcfa_mem #(
        .DEPTH (FRAME_DEPTH),
        .WIDTH (SUM_W)
    ) u_mem_right (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (seq_stat.clearing ? '0 : wr_sum[LANE_RIGHT]),
        .i_rd_en   (in_accept),
        .i_rd_addr (seq_pos),
        .o_rd_data (rd_sum[LANE_RIGHT])
    );

    // ------------------------------------------------------------------
    // Stage 1: capture the item with its position and frame flags.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_left       <= i_in.left_sample;
            r_s1_right      <= i_in.right_sample;
            r_s1_addr       <= seq_pos;
            r_s1_last_frame <= seq_stat.last_frame;
            r_s1_last_elem  <= seq_stat.last_elem;
        end
    end

    // Add the sample into the stored sum; clear the entry on the last frame.
    assign total[LANE_LEFT] =
        {{(TOT_W-SUM_W){rd_sum[LANE_LEFT][SUM_W-1]}}, rd_sum[LANE_LEFT]} +
        {{(TOT_W-SAMPLE_WIDTH){r_s1_left[SAMPLE_WIDTH-1]}}, r_s1_left};
    assign total[LANE_RIGHT] =
        {{(TOT_W-SUM_W){rd_sum[LANE_RIGHT][SUM_W-1]}}, rd_sum[LANE_RIGHT]} +
        {{(TOT_W-SAMPLE_WIDTH){r_s1_right[SAMPLE_WIDTH-1]}}, r_s1_right};

    assign wr_sum[LANE_LEFT]  = r_s1_last_frame ? '0 : total[LANE_LEFT][SUM_W-1:0];
    assign wr_sum[LANE_RIGHT] = r_s1_last_frame ? '0 : total[LANE_RIGHT][SUM_W-1:0];

    assign s1_tag.elem_index = ELEM_W'(r_s1_addr);
    assign s1_tag.last       = r_s1_last_elem;

    // ------------------------------------------------------------------
    // Divide by the frame count, last frame only.
    // ------------------------------------------------------------------
    tcfa_div #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .STEP_BITS    (DIV_STEP_BITS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_valid   (r_s1_valid && r_s1_last_frame),
        .i_tag     (s1_tag),
        .i_total   (total),
        .i_divisor (divisor),
        .o_valid   (div_valid),
        .o_tag     (div_tag),
        .o_average (div_avg)
    );

    // ------------------------------------------------------------------
    // Output register: load from the divider tail, drop on transfer.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (div_valid && advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_valid && advance) begin
            r_out_left  <= div_avg[LANE_LEFT];
            r_out_right <= div_avg[LANE_RIGHT];
            r_out_tag   <= div_tag;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.left_average  = r_out_left;
    assign o_out.right_average = r_out_right;
    assign o_out.element_index = r_out_tag.elem_index;
    assign o_out.last_of_frame = r_out_tag.last;

    `TCFA_ASSERT_IMP(a_clear_no_rmw, i_clk, i_rst_n, seq_stat.clearing, !r_s1_valid, "item in write-back stage during clearing pass")
    `TCFA_ASSERT_NXT(a_s1_holds, i_clk, i_rst_n, r_s1_valid && !advance, r_s1_valid && $stable(r_s1_addr), "write-back stage lost its item while stalled")
    `TCFA_ASSERT_NXT(a_div_holds, i_clk, i_rst_n, div_valid && !advance, div_valid, "divider result dropped while output stalled")

endmodule

`default_nettype wire
